// ===== sv/rvd_pkg.sv =====
// Package for the RV64I-subset instruction decoder.
// Holds opcode, mnemonic and operand-layout codes and the decoded-request struct.
// No dependencies.
package rvd_pkg;

	localparam logic [6:0] OP_LUI   = 7'd55;
	localparam logic [6:0] OP_JAL   = 7'd111;
	localparam logic [6:0] OP_JALR  = 7'd103;
	localparam logic [6:0] OP_LOAD  = 7'd3;
	localparam logic [6:0] OP_STORE = 7'd35;
	localparam logic [6:0] OP_REG   = 7'd51;
	localparam logic [6:0] OP_IMMW  = 7'd27;
	localparam logic [6:0] OP_IMM   = 7'd19;

	localparam logic [6:0] F7_BASE = 7'd0;
	localparam logic [6:0] F7_ALT  = 7'd32;
	localparam logic [5:0] F6_BASE = 6'd0;
	localparam logic [5:0] F6_ALT  = 6'd16;

	localparam logic [4:0] MN_INVALID = 5'd0;
	localparam logic [4:0] MN_ADD     = 5'd1;
	localparam logic [4:0] MN_SUB     = 5'd2;
	localparam logic [4:0] MN_SLL     = 5'd3;
	localparam logic [4:0] MN_XOR     = 5'd4;
	localparam logic [4:0] MN_SRL     = 5'd5;
	localparam logic [4:0] MN_SRA     = 5'd6;
	localparam logic [4:0] MN_OR      = 5'd7;
	localparam logic [4:0] MN_AND     = 5'd8;
	localparam logic [4:0] MN_LUI     = 5'd9;
	localparam logic [4:0] MN_JAL     = 5'd10;
	localparam logic [4:0] MN_JALR    = 5'd11;
	localparam logic [4:0] MN_LB      = 5'd12;
	localparam logic [4:0] MN_LH      = 5'd13;
	localparam logic [4:0] MN_LW      = 5'd14;
	localparam logic [4:0] MN_SB      = 5'd15;
	localparam logic [4:0] MN_SH      = 5'd16;
	localparam logic [4:0] MN_SW      = 5'd17;
	localparam logic [4:0] MN_ADDI    = 5'd18;
	localparam logic [4:0] MN_XORI    = 5'd19;
	localparam logic [4:0] MN_ORI     = 5'd20;
	localparam logic [4:0] MN_ANDI    = 5'd21;
	localparam logic [4:0] MN_LWU     = 5'd22;
	localparam logic [4:0] MN_LD      = 5'd23;
	localparam logic [4:0] MN_SD      = 5'd24;
	localparam logic [4:0] MN_SLLI    = 5'd25;
	localparam logic [4:0] MN_SRLI    = 5'd26;
	localparam logic [4:0] MN_SLLIW   = 5'd27;
	localparam logic [4:0] MN_SRLIW   = 5'd28;
	localparam logic [4:0] MN_SRAIW   = 5'd29;
	localparam logic [4:0] MN_SRAI    = 5'd30;

	localparam logic [2:0] LAY_NONE  = 3'd0;
	localparam logic [2:0] LAY_RR    = 3'd1;
	localparam logic [2:0] LAY_RI    = 3'd2;
	localparam logic [2:0] LAY_LOAD  = 3'd3;
	localparam logic [2:0] LAY_STORE = 3'd4;
	localparam logic [2:0] LAY_UPPER = 3'd5;
	localparam logic [2:0] LAY_JUMP  = 3'd6;
	localparam logic [2:0] LAY_SHIFT = 3'd7;

	typedef struct packed {
		logic [4:0]  mnemonic;
		logic [2:0]  layout;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
		logic [5:0]  shamt;
	} dec_t;

endpackage

// ===== sv/rv64i_subset_instruction_decoder.sv =====
// RV64I-subset instruction decoder, top level.
// Depends on rvd_pkg and rvd_decode.
//
// Usage:
//   Request channel: drive instr_word and raise start. A request is taken at
//   each rising edge where start is high and busy is low. busy is held low,
//   so a new instruction word may be presented in every cycle.
//   Result channel: done pulses for one cycle with mnemonic_code,
//   operand_layout, dest_reg, src1_reg, src2_reg, immediate and
//   shift_amount valid. Results are not held; the receiver has to take them
//   in that cycle and cannot stall the block.
// Pipeline: an accepted word goes into the input register, then through the
//   decode logic into the result register that drives the outputs.
// Throughput: one instruction per cycle, set by the single decode stage.
// Reset: arst_n low clears the valid flags of both stages; no result is
//   reported until a new request is taken. Payload registers are not reset.
module rv64i_subset_instruction_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        instr_word,
	output logic               done,
	output logic [4:0]         mnemonic_code,
	output logic [2:0]         operand_layout,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic signed [31:0] immediate,
	output logic [5:0]         shift_amount
);
	import rvd_pkg::*;

	logic        vld_s1;
	logic [31:0] instr_s1;
	dec_t        dec;
	logic        vld_s2;
	dec_t        res_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			instr_s1 <= instr_word;
		end
		if (vld_s1) begin
			res_s2 <= dec;
		end
	end

	rvd_decode u_decode (
		.instr_word (instr_s1),
		.dec        (dec)
	);

	assign done           = vld_s2;
	assign mnemonic_code  = res_s2.mnemonic;
	assign operand_layout = res_s2.layout;
	assign dest_reg       = res_s2.rd;
	assign src1_reg       = res_s2.rs1;
	assign src2_reg       = res_s2.rs2;
	assign immediate      = res_s2.imm;
	assign shift_amount   = res_s2.shamt;

endmodule

// ===== sv/rvd_decode.sv =====
// Combinational decode of one RV64I-subset instruction word.
// Depends on rvd_pkg for codes and the dec_t struct.
module rvd_decode (
	input  logic [31:0]  instr_word,
	output rvd_pkg::dec_t dec
);
	import rvd_pkg::*;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [5:0]  f6;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [4:0]  code;
	logic [2:0]  lay;
	logic [31:0] imm;
	logic [5:0]  sh;

	assign opc   = instr_word[6:0];
	assign f3    = instr_word[14:12];
	assign f7    = instr_word[31:25];
	assign f6    = instr_word[31:26];
	assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
	assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
	assign imm_j = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
		instr_word[30:21], 1'b0};
	assign imm_u = {instr_word[31:12], 12'd0};

	always_comb begin
		code = MN_INVALID;
		lay  = LAY_NONE;
		imm  = '0;
		sh   = '0;
		unique case (opc)
			OP_REG: begin
				if (f7 == F7_BASE) begin
					unique case (f3)
						3'd0: code = MN_ADD;
						3'd1: code = MN_SLL;
						3'd4: code = MN_XOR;
						3'd5: code = MN_SRL;
						3'd6: code = MN_OR;
						3'd7: code = MN_AND;
						default: code = MN_INVALID;
					endcase
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) begin
						code = MN_SUB;
					end else if (f3 == 3'd5) begin
						code = MN_SRA;
					end
				end
				if (code != MN_INVALID) begin
					lay = LAY_RR;
				end
			end
			OP_LUI: begin
				code = MN_LUI;
				lay  = LAY_UPPER;
				imm  = imm_u;
			end
			OP_JAL: begin
				code = MN_JAL;
				lay  = LAY_JUMP;
				imm  = imm_j;
			end
			OP_JALR: begin
				code = MN_JALR;
				lay  = LAY_RI;
				imm  = imm_i;
			end
			OP_LOAD: begin
				unique case (f3)
					3'd0: code = MN_LB;
					3'd1: code = MN_LH;
					3'd2: code = MN_LW;
					3'd3: code = MN_LD;
					3'd6: code = MN_LWU;
					default: code = MN_INVALID;
				endcase
				if (code != MN_INVALID) begin
					lay = LAY_LOAD;
					imm = imm_i;
				end
			end
			OP_STORE: begin
				unique case (f3)
					3'd0: code = MN_SB;
					3'd1: code = MN_SH;
					3'd2: code = MN_SW;
					3'd3: code = MN_SD;
					default: code = MN_INVALID;
				endcase
				if (code != MN_INVALID) begin
					lay = LAY_STORE;
					imm = imm_s;
				end
			end
			OP_IMM: begin
				unique case (f3)
					3'd0: begin
						code = MN_ADDI;
						lay  = LAY_RI;
						imm  = imm_i;
					end
					3'd4: begin
						code = MN_XORI;
						lay  = LAY_RI;
						imm  = imm_i;
					end
					3'd6: begin
						code = MN_ORI;
						lay  = LAY_RI;
						imm  = imm_i;
					end
					3'd7: begin
						code = MN_ANDI;
						lay  = LAY_RI;
						imm  = imm_i;
					end
					3'd1: begin
						if (f6 == F6_BASE) begin
							code = MN_SLLI;
						end
					end
					3'd5: begin
						if (f6 == F6_BASE) begin
							code = MN_SRLI;
						end else if (f6 == F6_ALT) begin
							code = MN_SRAI;
						end
					end
					default: code = MN_INVALID;
				endcase
				if (code == MN_SLLI || code == MN_SRLI || code == MN_SRAI) begin
					lay = LAY_SHIFT;
					sh  = instr_word[25:20];
				end
			end
			OP_IMMW: begin
				if (f3 == 3'd1 && f7 == F7_BASE) begin
					code = MN_SLLIW;
				end else if (f3 == 3'd5 && f7 == F7_BASE) begin
					code = MN_SRLIW;
				end else if (f3 == 3'd5 && f7 == F7_ALT) begin
					code = MN_SRAIW;
				end
				if (code != MN_INVALID) begin
					lay = LAY_SHIFT;
					sh  = instr_word[25:20];
				end
			end
			default: begin
				code = MN_INVALID;
			end
		endcase
	end

	assign dec.mnemonic = code;
	assign dec.layout   = lay;
	assign dec.rd       = instr_word[11:7];
	assign dec.rs1      = instr_word[19:15];
	assign dec.rs2      = instr_word[24:20];
	assign dec.imm      = imm;
	assign dec.shamt    = sh;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for rv64i_subset_instruction_decoder: random and directed instruction words,
// with each decoded request checked field by field against a decoder written in this file.
// Depends on rvd_pkg and the decoder RTL.
module testbench;
	import rvd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam int CALM_TAIL = 100;

	localparam logic [2:0] F3_ADD_SUB = 3'd0;
	localparam logic [2:0] F3_SLL     = 3'd1;
	localparam logic [2:0] F3_SLT     = 3'd2;
	localparam logic [2:0] F3_XOR     = 3'd4;
	localparam logic [2:0] F3_SR      = 3'd5;
	localparam logic [2:0] F3_OR      = 3'd6;
	localparam logic [2:0] F3_AND     = 3'd7;
	localparam logic [2:0] F3_B       = 3'd0;
	localparam logic [2:0] F3_H       = 3'd1;
	localparam logic [2:0] F3_W       = 3'd2;
	localparam logic [2:0] F3_D       = 3'd3;
	localparam logic [2:0] F3_WU      = 3'd6;

	typedef struct {
		logic [31:0] word;
		bit          drain;
	} instr_req_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start = 1'b0;
	logic               busy;
	logic [31:0]        instr_word = '0;
	logic               done;
	logic [4:0]         mnemonic_code;
	logic [2:0]         operand_layout;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic signed [31:0] immediate;
	logic [5:0]         shift_amount;

	instr_req_t  fetch_queue[$];
	dec_t        decoded_expect[$];
	int          total_items;
	int          accepted_count;
	int          result_count;
	int          invalid_count;
	int          error_count;
	int          cycle_count;
	int          gap_left;
	logic [31:0] mnemonic_seen;
	logic        drv_start;
	logic [31:0] drv_word;

	rv64i_subset_instruction_decoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.instr_word     (instr_word),
		.done           (done),
		.mnemonic_code  (mnemonic_code),
		.operand_layout (operand_layout),
		.dest_reg       (dest_reg),
		.src1_reg       (src1_reg),
		.src2_reg       (src2_reg),
		.immediate      (immediate),
		.shift_amount   (shift_amount)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] encode(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
		return {f7, rs2, rs1, f3, rd, opc};
	endfunction

	function automatic dec_t decode_instr(logic [31:0] w);
		dec_t        d;
		logic [6:0]  f7;
		logic [5:0]  f6;
		logic [2:0]  f3;
		logic [31:0] i_imm;
		f7 = w[31:25];
		f6 = w[31:26];
		f3 = w[14:12];
		i_imm = {{20{w[31]}}, w[31:20]};
		d = '0;
		d.mnemonic = MN_INVALID;
		d.layout = LAY_NONE;
		d.rd = w[11:7];
		d.rs1 = w[19:15];
		d.rs2 = w[24:20];
		case (w[6:0])
			OP_REG: begin
				if (f7 == F7_BASE) begin
					case (f3)
						F3_ADD_SUB: d.mnemonic = MN_ADD;
						F3_SLL:     d.mnemonic = MN_SLL;
						F3_XOR:     d.mnemonic = MN_XOR;
						F3_SR:      d.mnemonic = MN_SRL;
						F3_OR:      d.mnemonic = MN_OR;
						F3_AND:     d.mnemonic = MN_AND;
						default:    d.mnemonic = MN_INVALID;
					endcase
				end else if (f7 == F7_ALT) begin
					if (f3 == F3_ADD_SUB)
						d.mnemonic = MN_SUB;
					else if (f3 == F3_SR)
						d.mnemonic = MN_SRA;
				end
				if (d.mnemonic != MN_INVALID)
					d.layout = LAY_RR;
			end
			OP_LUI: begin
				d.mnemonic = MN_LUI;
				d.layout = LAY_UPPER;
				d.imm = {w[31:12], 12'b0};
			end
			OP_JAL: begin
				d.mnemonic = MN_JAL;
				d.layout = LAY_JUMP;
				d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			end
			OP_JALR: begin
				d.mnemonic = MN_JALR;
				d.layout = LAY_RI;
				d.imm = i_imm;
			end
			OP_LOAD: begin
				case (f3)
					F3_B:    d.mnemonic = MN_LB;
					F3_H:    d.mnemonic = MN_LH;
					F3_W:    d.mnemonic = MN_LW;
					F3_D:    d.mnemonic = MN_LD;
					F3_WU:   d.mnemonic = MN_LWU;
					default: d.mnemonic = MN_INVALID;
				endcase
				if (d.mnemonic != MN_INVALID) begin
					d.layout = LAY_LOAD;
					d.imm = i_imm;
				end
			end
			OP_STORE: begin
				case (f3)
					F3_B:    d.mnemonic = MN_SB;
					F3_H:    d.mnemonic = MN_SH;
					F3_W:    d.mnemonic = MN_SW;
					F3_D:    d.mnemonic = MN_SD;
					default: d.mnemonic = MN_INVALID;
				endcase
				if (d.mnemonic != MN_INVALID) begin
					d.layout = LAY_STORE;
					d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
				end
			end
			OP_IMM: begin
				case (f3)
					F3_ADD_SUB: d.mnemonic = MN_ADDI;
					F3_XOR:     d.mnemonic = MN_XORI;
					F3_OR:      d.mnemonic = MN_ORI;
					F3_AND:     d.mnemonic = MN_ANDI;
					F3_SLL:     d.mnemonic = (f6 == F6_BASE) ? MN_SLLI : MN_INVALID;
					F3_SR: begin
						if (f6 == F6_BASE)
							d.mnemonic = MN_SRLI;
						else if (f6 == F6_ALT)
							d.mnemonic = MN_SRAI;
					end
					default:    d.mnemonic = MN_INVALID;
				endcase
				if (d.mnemonic == MN_SLLI || d.mnemonic == MN_SRLI || d.mnemonic == MN_SRAI) begin
					d.layout = LAY_SHIFT;
					d.shamt = w[25:20];
				end else if (d.mnemonic != MN_INVALID) begin
					d.layout = LAY_RI;
					d.imm = i_imm;
				end
			end
			OP_IMMW: begin
				if (f3 == F3_SLL && f7 == F7_BASE)
					d.mnemonic = MN_SLLIW;
				else if (f3 == F3_SR && f7 == F7_BASE)
					d.mnemonic = MN_SRLIW;
				else if (f3 == F3_SR && f7 == F7_ALT)
					d.mnemonic = MN_SRAIW;
				if (d.mnemonic != MN_INVALID) begin
					d.layout = LAY_SHIFT;
					d.shamt = w[25:20];
				end
			end
			default: d.mnemonic = MN_INVALID;
		endcase
		return d;
	endfunction

	// mostly well-formed words: a real opcode, and a top field that hits the funct6/funct7 checks
	function automatic logic [31:0] random_instr();
		logic [6:0] opc;
		logic [6:0] f7;
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		case ($urandom_range(0, 7))
			0:       opc = OP_REG;
			1:       opc = OP_LUI;
			2:       opc = OP_JAL;
			3:       opc = OP_JALR;
			4:       opc = OP_LOAD;
			5:       opc = OP_STORE;
			6:       opc = OP_IMMW;
			default: opc = OP_IMM;
		endcase
		case ($urandom_range(0, 4))
			0:       f7 = F7_BASE;
			1:       f7 = F7_ALT;
			2:       f7 = F7_BASE | 7'd1;
			3:       f7 = F7_ALT | 7'd1;
			default: f7 = 7'($urandom);
		endcase
		return encode(f7, 5'($urandom), 5'($urandom), 3'($urandom), 5'($urandom), opc);
	endfunction

	task automatic add_req(logic [31:0] w, bit drain);
		fetch_queue.push_back('{w, drain});
	endtask

	task automatic flag_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR @%0d: %s", cycle_count, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			instr_word <= '0;
			gap_left = 0;
		end else begin
			drv_start = 1'b0;
			drv_word = $urandom;
			if (start && !busy) begin
				decoded_expect.push_back(decode_instr(instr_word));
				accepted_count++;
				if (accepted_count < total_items - CALM_TAIL && (accepted_count / 150) % 3 != 1
						&& $urandom_range(0, 4) == 0)
					gap_left = $urandom_range(1, 7);
			end
			if (start && busy) begin
				drv_start = 1'b1;
				drv_word = instr_word;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (fetch_queue.size() > 0
					&& !(fetch_queue[0].drain && decoded_expect.size() > 0)) begin
				drv_start = 1'b1;
				drv_word = fetch_queue[0].word;
				void'(fetch_queue.pop_front());
			end
			start <= drv_start;
			instr_word <= drv_word;
		end
	end

	always @(posedge clk) begin
		dec_t got;
		dec_t want;
		if (arst_n && done === 1'b1) begin
			got = {mnemonic_code, operand_layout, dest_reg, src1_reg, src2_reg, immediate,
				shift_amount};
			result_count++;
			if (decoded_expect.size() == 0) begin
				flag_error("result with no request outstanding");
			end else begin
				want = decoded_expect.pop_front();
				if (got !== want)
					flag_error($sformatf({"mn %0d/%0d lay %0d/%0d rd %0d/%0d rs1 %0d/%0d ",
						"rs2 %0d/%0d imm %h/%h sh %0d/%0d (expected/actual)"},
						want.mnemonic, got.mnemonic, want.layout, got.layout, want.rd, got.rd,
						want.rs1, got.rs1, want.rs2, got.rs2, want.imm, got.imm,
						want.shamt, got.shamt));
				else begin
					mnemonic_seen[got.mnemonic] = 1'b1;
					if (got.mnemonic == MN_INVALID)
						invalid_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		mnemonic_seen = '0;

		add_req(32'h0000_0000, 1'b0);
		add_req(32'hFFFF_FFFF, 1'b0);
		add_req(encode(F7_BASE, 5'd31, 5'd31, F3_ADD_SUB, 5'd31, OP_REG), 1'b0);
		add_req(encode(F7_ALT, 5'd0, 5'd0, F3_ADD_SUB, 5'd0, OP_REG), 1'b0);
		add_req(encode(F7_ALT, 5'd5, 5'd6, F3_SR, 5'd7, OP_REG), 1'b0);
		add_req(encode(F7_ALT, 5'd1, 5'd2, F3_SLL, 5'd3, OP_REG), 1'b0);
		add_req(encode(F7_BASE, 5'd1, 5'd2, F3_SLT, 5'd3, OP_REG), 1'b0);
		add_req({20'hFFFFF, 5'd1, OP_LUI}, 1'b0);
		add_req({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd1, OP_JAL}, 1'b0);
		add_req({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd2, OP_JAL}, 1'b0);
		add_req(encode(7'h7F, 5'd31, 5'd4, F3_AND, 5'd5, OP_JALR), 1'b0);
		add_req(encode(7'h40, 5'd0, 5'd8, F3_B, 5'd9, OP_LOAD), 1'b0);
		add_req(encode(7'h3F, 5'd31, 5'd8, F3_D, 5'd9, OP_LOAD), 1'b0);
		add_req(encode(7'h15, 5'd3, 5'd8, F3_WU, 5'd9, OP_LOAD), 1'b0);
		add_req(encode(7'h15, 5'd3, 5'd8, F3_AND, 5'd9, OP_LOAD), 1'b0);
		add_req(encode(7'h7F, 5'd2, 5'd1, F3_B, 5'd31, OP_STORE), 1'b0);
		add_req(encode(7'h3F, 5'd2, 5'd1, F3_D, 5'd31, OP_STORE), 1'b0);
		add_req(encode(7'h01, 5'd2, 5'd1, F3_XOR, 5'd0, OP_STORE), 1'b0);
		add_req(encode(7'h7F, 5'd31, 5'd1, F3_ADD_SUB, 5'd1, OP_IMM), 1'b0);
		add_req(encode(7'h3F, 5'd31, 5'd1, F3_AND, 5'd1, OP_IMM), 1'b0);
		add_req(encode(F7_BASE | 7'd1, 5'd31, 5'd2, F3_SLL, 5'd3, OP_IMM), 1'b0);
		add_req(encode(F7_ALT | 7'd1, 5'd31, 5'd2, F3_SR, 5'd3, OP_IMM), 1'b0);
		add_req(encode(7'd2, 5'd4, 5'd2, F3_SR, 5'd3, OP_IMM), 1'b0);
		add_req(encode(F7_BASE, 5'd31, 5'd2, F3_SLL, 5'd3, OP_IMMW), 1'b0);
		add_req(encode(F7_ALT, 5'd31, 5'd2, F3_SR, 5'd3, OP_IMMW), 1'b0);
		add_req(encode(F7_BASE, 5'd1, 5'd2, F3_ADD_SUB, 5'd3, OP_IMMW), 1'b0);
		add_req(encode(F7_BASE | 7'd1, 5'd1, 5'd2, F3_SLL, 5'd3, OP_IMMW), 1'b0);
		for (int n = 0; n < 1300; n++)
			add_req(random_instr(), n % 400 == 0);
		total_items = fetch_queue.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (fetch_queue.size() > 0 || start || decoded_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (decoded_expect.size() != 0)
			flag_error($sformatf("%0d requests never produced a result", decoded_expect.size()));

		$display("decoded %0d of %0d instruction words, %0d invalid encodings",
			result_count, accepted_count, invalid_count);
		$display("%0d distinct mnemonic codes seen in %0d cycles",
			$countones(mnemonic_seen), cycle_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/rvd_pkg.sv
sv/rvd_decode.sv
sv/rv64i_subset_instruction_decoder.sv
tb/sv/testbench.sv
